// ===== rtl/core/qrpt_pkg.sv =====
// ----------------------------------------------------------------------------
// qrpt_pkg
// Types, register indexes and saturation helpers shared by the rigid point
// transform unit.
// ----------------------------------------------------------------------------
package qrpt_pkg;

    localparam int NUM_REGS  = 7;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_QUAT_X   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_QUAT_Y   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_QUAT_Z   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_QUAT_W   = 3'd6;

    localparam logic signed [31:0] QUAT_W_RESET = 32'sh4000_0000;   // 1.0 in Q2.30

    // cycles from a register write to a settled rotation matrix
    localparam int MAT_LAT  = 3;
    localparam int SETTLE_W = $clog2(MAT_LAT + 1);

    localparam logic signed [36:0] SAT32_MAX = 37'sd2147483647;
    localparam logic signed [36:0] SAT32_MIN = -37'sd2147483648;

    typedef struct packed {
        logic signed [31:0] quat_w;
        logic signed [31:0] quat_z;
        logic signed [31:0] quat_y;
        logic signed [31:0] quat_x;
        logic [2:0][31:0]   offset;
    } cfg_t;

    // rotation matrix, Q2.30, entry r*3+c
    typedef logic [8:0][31:0] mat_t;

    // beat layouts, last-declared field (pos_x) in the lowest bits
    typedef struct packed {
        logic [31:0]        inten_bits;
        logic [31:0]        curv_bits;
        logic signed [15:0] norm_z;
        logic signed [15:0] norm_y;
        logic signed [15:0] norm_x;
        logic signed [31:0] pos_z;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_x;
    } in_item_t;

    typedef struct packed {
        logic [31:0]        out_inten_bits;
        logic [31:0]        out_curv_bits;
        logic signed [15:0] out_norm_z;
        logic signed [15:0] out_norm_y;
        logic signed [15:0] out_norm_x;
        logic signed [31:0] out_pos_z;
        logic signed [31:0] out_pos_y;
        logic signed [31:0] out_pos_x;
    } out_item_t;

    function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
        logic signed [31:0] r;
        if (v > SAT32_MAX)
            r = 32'sh7FFF_FFFF;
        else if (v < SAT32_MIN)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

// ===== rtl/core/qrpt_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// qrpt_cfg_regs
// Pose registers and the settle counter that covers the matrix rebuild.
// ----------------------------------------------------------------------------
module qrpt_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [qrpt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                    cfg_data,
    output qrpt_pkg::cfg_t                 cfg,
    output logic                           settled
);
    import qrpt_pkg::*;

    cfg_t                cfg_reg;
    logic [SETTLE_W-1:0] settle_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.offset <= '0;
            cfg_reg.quat_x <= '0;
            cfg_reg.quat_y <= '0;
            cfg_reg.quat_z <= '0;
            cfg_reg.quat_w <= QUAT_W_RESET;
            settle_reg     <= SETTLE_W'(MAT_LAT);
        end
        else
        begin
            if (cfg_we)
            begin
                settle_reg <= SETTLE_W'(MAT_LAT);
                unique case (cfg_index)
                    REG_OFFSET_X: cfg_reg.offset[0] <= cfg_data;
                    REG_OFFSET_Y: cfg_reg.offset[1] <= cfg_data;
                    REG_OFFSET_Z: cfg_reg.offset[2] <= cfg_data;
                    REG_QUAT_X:   cfg_reg.quat_x    <= cfg_data;
                    REG_QUAT_Y:   cfg_reg.quat_y    <= cfg_data;
                    REG_QUAT_Z:   cfg_reg.quat_z    <= cfg_data;
                    REG_QUAT_W:   cfg_reg.quat_w    <= cfg_data;
                    default:      ;   // unused index: write dropped
                endcase
            end
            else if (settle_reg != '0)
            begin
                settle_reg <= settle_reg - 1'b1;
            end
        end
    end

    assign cfg     = cfg_reg;
    assign settled = (settle_reg == '0);

endmodule

// ===== rtl/core/qrpt_matrix.sv =====
// ----------------------------------------------------------------------------
// qrpt_matrix
// Three-stage build of the Q2.30 rotation matrix from the quaternion.
// ----------------------------------------------------------------------------
module qrpt_matrix (
    input  logic           clk,
    input  qrpt_pkg::cfg_t cfg,
    output qrpt_pkg::mat_t mat
);
    import qrpt_pkg::*;

    localparam int XX = 0;
    localparam int YY = 1;
    localparam int ZZ = 2;
    localparam int XY = 3;
    localparam int XZ = 4;
    localparam int YZ = 5;
    localparam int WX = 6;
    localparam int WY = 7;
    localparam int WZ = 8;

    localparam logic signed [63:0] HALF_29 = 64'sd268435456;     // 2^28
    localparam logic signed [36:0] ONE_Q30 = 37'sd1073741824;

    logic signed [63:0] prod_next  [9];
    logic signed [63:0] prod_reg   [9];
    logic signed [34:0] twice_next [9];
    logic signed [34:0] twice_reg  [9];
    logic signed [36:0] t          [9];
    logic signed [36:0] ent        [9];
    mat_t               mat_next;
    mat_t               mat_reg;

    // stage 1: exact quaternion products, Q4.60
    always_comb
    begin
        prod_next[XX] = cfg.quat_x * cfg.quat_x;
        prod_next[YY] = cfg.quat_y * cfg.quat_y;
        prod_next[ZZ] = cfg.quat_z * cfg.quat_z;
        prod_next[XY] = cfg.quat_x * cfg.quat_y;
        prod_next[XZ] = cfg.quat_x * cfg.quat_z;
        prod_next[YZ] = cfg.quat_y * cfg.quat_z;
        prod_next[WX] = cfg.quat_w * cfg.quat_x;
        prod_next[WY] = cfg.quat_w * cfg.quat_y;
        prod_next[WZ] = cfg.quat_w * cfg.quat_z;
    end

    // stage 2: 2ab in Q5.30, round half up
    always_comb
    begin
        logic signed [63:0] rnd;
        for (int k = 0; k < 9; k++)
        begin
            rnd           = prod_reg[k] + HALF_29;
            twice_next[k] = rnd[63:29];
        end
    end

    // stage 3: entries, saturated
    always_comb
    begin
        for (int k = 0; k < 9; k++)
            t[k] = {{2{twice_reg[k][34]}}, twice_reg[k]};
        ent[0] = ONE_Q30 - t[YY] - t[ZZ];
        ent[1] = t[XY] - t[WZ];
        ent[2] = t[XZ] + t[WY];
        ent[3] = t[XY] + t[WZ];
        ent[4] = ONE_Q30 - t[XX] - t[ZZ];
        ent[5] = t[YZ] - t[WX];
        ent[6] = t[XZ] - t[WY];
        ent[7] = t[YZ] + t[WX];
        ent[8] = ONE_Q30 - t[XX] - t[YY];
        for (int k = 0; k < 9; k++)
            mat_next[k] = sat32(ent[k]);
    end

    always_ff @(posedge clk)
    begin
        prod_reg  <= prod_next;
        twice_reg <= twice_next;
        mat_reg   <= mat_next;
    end

    assign mat = mat_reg;

endmodule

// ===== rtl/core/qrpt_datapath.sv =====
// ----------------------------------------------------------------------------
// qrpt_datapath
// Three-stage point pipeline: products, rounded sums, offset and saturation.
// ----------------------------------------------------------------------------
module qrpt_datapath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  qrpt_pkg::mat_t        mat,
    input  qrpt_pkg::cfg_t        cfg,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  qrpt_pkg::in_item_t    in_item,
    output logic                  out_valid,
    input  logic                  out_ready,
    output qrpt_pkg::out_item_t   out_item
);
    import qrpt_pkg::*;

    localparam logic signed [65:0] HALF_P = 66'sd536870912;   // 2^29
    localparam logic signed [49:0] HALF_N = 50'sd536870912;

    logic s1_valid_reg;
    logic s2_valid_reg;
    logic s3_valid_reg;
    logic ready1;
    logic ready2;
    logic ready3;

    logic signed [31:0] pin [3];
    logic signed [15:0] nin [3];

    logic signed [63:0] pprod_next [9];
    logic signed [47:0] nprod_next [9];
    logic signed [63:0] pprod_reg  [9];
    logic signed [47:0] nprod_reg  [9];
    logic [31:0]        curv1_reg, inten1_reg;

    logic signed [35:0] psum_next [3];
    logic signed [19:0] nsum_next [3];
    logic signed [35:0] psum_reg  [3];
    logic signed [19:0] nsum_reg  [3];
    logic [31:0]        curv2_reg, inten2_reg;

    logic signed [31:0] pout_next [3];
    logic signed [15:0] nout_next [3];
    out_item_t          out_reg;

    // bubbles collapse: a stage moves when empty or when the next one moves
    assign ready3   = !s3_valid_reg || out_ready;
    assign ready2   = !s2_valid_reg || ready3;
    assign ready1   = !s1_valid_reg || ready2;
    assign in_ready = ready1;

    assign pin[0] = in_item.pos_x;
    assign pin[1] = in_item.pos_y;
    assign pin[2] = in_item.pos_z;
    assign nin[0] = in_item.norm_x;
    assign nin[1] = in_item.norm_y;
    assign nin[2] = in_item.norm_z;

    // stage 1: R*p (Q18.46) and R*n (Q4.44)
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                pprod_next[r*3+c] = $signed(mat[r*3+c]) * pin[c];
                nprod_next[r*3+c] = $signed(mat[r*3+c]) * nin[c];
            end
        end
    end

    // stage 2: exact row sums, rounded half up to Q20.16 / Q6.14
    always_comb
    begin
        logic signed [65:0] ps;
        logic signed [49:0] ns;
        for (int r = 0; r < 3; r++)
        begin
            ps = {{2{pprod_reg[r*3][63]}}, pprod_reg[r*3]}
               + {{2{pprod_reg[r*3+1][63]}}, pprod_reg[r*3+1]}
               + {{2{pprod_reg[r*3+2][63]}}, pprod_reg[r*3+2]}
               + HALF_P;
            ns = {{2{nprod_reg[r*3][47]}}, nprod_reg[r*3]}
               + {{2{nprod_reg[r*3+1][47]}}, nprod_reg[r*3+1]}
               + {{2{nprod_reg[r*3+2][47]}}, nprod_reg[r*3+2]}
               + HALF_N;
            psum_next[r] = ps[65:30];
            nsum_next[r] = ns[49:30];
        end
    end

    // stage 3: translation and saturation
    always_comb
    begin
        logic signed [36:0] pt;
        for (int r = 0; r < 3; r++)
        begin
            pt = {psum_reg[r][35], psum_reg[r]}
               + {{5{cfg.offset[r][31]}}, cfg.offset[r]};
            pout_next[r] = sat32(pt);
            if (nsum_reg[r] > 20'sd32767)
                nout_next[r] = 16'sh7FFF;
            else if (nsum_reg[r] < -20'sd32768)
                nout_next[r] = 16'sh8000;
            else
                nout_next[r] = nsum_reg[r][15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (ready1)
                s1_valid_reg <= in_valid;
            if (ready2)
                s2_valid_reg <= s1_valid_reg;
            if (ready3)
                s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready1 && in_valid)
        begin
            pprod_reg  <= pprod_next;
            nprod_reg  <= nprod_next;
            curv1_reg  <= in_item.curv_bits;
            inten1_reg <= in_item.inten_bits;
        end
        if (ready2 && s1_valid_reg)
        begin
            psum_reg   <= psum_next;
            nsum_reg   <= nsum_next;
            curv2_reg  <= curv1_reg;
            inten2_reg <= inten1_reg;
        end
        if (ready3 && s2_valid_reg)
        begin
            out_reg.out_pos_x      <= pout_next[0];
            out_reg.out_pos_y      <= pout_next[1];
            out_reg.out_pos_z      <= pout_next[2];
            out_reg.out_norm_x     <= nout_next[0];
            out_reg.out_norm_y     <= nout_next[1];
            out_reg.out_norm_z     <= nout_next[2];
            out_reg.out_curv_bits  <= curv2_reg;
            out_reg.out_inten_bits <= inten2_reg;
        end
    end

    assign out_valid = s3_valid_reg;
    assign out_item  = out_reg;

endmodule

// ===== rtl/core/quaternion_rigid_point_transform_unit.sv =====
// ----------------------------------------------------------------------------
// quaternion_rigid_point_transform_unit
// Applies a configured rigid pose (translation + unit quaternion) to a
// stream of oriented points.
// ----------------------------------------------------------------------------
// Usage
//   s_* carries one point per beat, m_* one transformed point per beat.
//   The pose sits in seven registers on the cfg_* write port (offsets x,y,z
//   in Q16.16, quaternion x,y,z,w in Q2.30); index 7 is ignored.
//   Position is rotated then translated, the normal only rotated; both
//   saturate. Curvature and intensity words pass straight through.
// Timing
//   An accepted s_ beat is registered by each stage in turn before m_tvalid.
//   Throughput: one beat per cycle while m_tready is high, set by the
//   three-stage multiply, sum, and offset/saturate pipeline; every
//   multiplier is 32x32 at most. After reset and every register write the
//   rotation matrix is rebuilt by its own 3-stage pipeline; s_tready stays
//   low until it settles. Write the pose only while the pipeline is empty.
// Stalls
//   m_tready low holds the output beat; earlier stages keep filling until
//   the pipeline is full, then s_tready drops. Nothing is lost or repeated.
// ----------------------------------------------------------------------------
module quaternion_rigid_point_transform_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    // pose register write port
    input  logic                           cfg_we,
    input  logic [qrpt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                    cfg_data,
    // input points
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, curv_bits, inten_bits
    input  logic [207:0]                   s_tdata,
    // output points
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // out_pos_x, out_pos_y, out_pos_z, out_norm_x, out_norm_y, out_norm_z,
    // out_curv_bits, out_inten_bits
    output logic [207:0]                   m_tdata
);
    import qrpt_pkg::*;

    cfg_t      cfg;
    mat_t      mat;
    logic      settled;
    logic      dp_ready;
    in_item_t  in_item;
    out_item_t out_item;

    qrpt_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .settled   (settled)
    );

    // matrix follows the quaternion registers; settled gates the input
    qrpt_matrix u_matrix (
        .clk (clk),
        .cfg (cfg),
        .mat (mat)
    );

    assign in_item  = s_tdata;
    assign s_tready = dp_ready && settled;

    qrpt_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .mat       (mat),
        .cfg       (cfg),
        .in_valid  (s_tvalid && settled),
        .in_ready  (dp_ready),
        .in_item   (in_item),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_item  (out_item)
    );

    assign m_tdata = out_item;

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the rigid point transform unit. A bit-exact
// predictor of the matrix build, the rotate/translate and the saturation runs
// beside the block. Each accepted output beat is checked field by field
// against the oldest prediction. Covered: directed corner points and poses,
// non-unit quaternions, ignored register writes, random poses and points
// under three idling mixes, and a long output stall that fills the pipeline.
// ----------------------------------------------------------------------------
module tb_top;
    import qrpt_pkg::*;

    localparam int PIPE_LAT   = 3;      // s_ beat to m_tvalid
    localparam int DRAIN_PAD  = PIPE_LAT + 2;
    localparam int STALL_LIM  = 3000;   // cycles with no beat on either side
    localparam int PRINT_CAP  = 40;
    localparam int POSE_SPAN  = 140;    // random points per random pose
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    localparam logic signed [95:0] ONE_Q30  = 96'sd1073741824;
    localparam logic signed [95:0] HALF_Q30 = 96'sd536870912;
    localparam logic signed [31:0] SIN45    = 32'sh2D41_3CCD;   // 0.7071 in Q2.30

    typedef logic signed [95:0] wide_t;
    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic signed [31:0] w;
    } quat_t;

    // DUT connections, all inputs known from time zero
    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_data  = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [207:0]         s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [207:0]         m_tdata;

    // predictor copy of the pose registers
    logic signed [31:0] pose_off [3];
    quat_t              pose_q;

    out_item_t expected_points [$];

    int src_gap_pct   = 0;      // % of cycles the sender idles before a beat
    int dst_gap_pct   = 0;      // % of cycles m_tready is dropped
    int hold_req      = 0;      // long receiver hold-off, picked up by the receiver
    int hold_left     = 0;
    int err_count     = 0;
    int points_sent   = 0;
    int points_seen   = 0;
    int poses_applied = 0;
    int quiet_cycles  = 0;

    quaternion_rigid_point_transform_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic logic signed [31:0] clamp32(input wide_t v);
        if (v > 96'sd2147483647)
            return 32'sh7FFF_FFFF;
        if (v < -96'sd2147483648)
            return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic logic signed [15:0] clamp16(input wide_t v);
        if (v > 96'sd32767)
            return 16'sh7FFF;
        if (v < -96'sd32768)
            return 16'sh8000;
        return v[15:0];
    endfunction

    // 2*a*b, Q2.30 in and out, round half up (arithmetic shift is a floor)
    function automatic wide_t twice_q30(input logic signed [31:0] a,
                                        input logic signed [31:0] b);
        wide_t pr;
        pr = a * b;
        return (pr + 96'sd268435456) >>> 29;
    endfunction

    function automatic out_item_t transform_point(input in_item_t pt);
        wide_t              e [3][3];
        logic signed [31:0] rot [3][3];
        logic signed [31:0] p [3];
        logic signed [15:0] n [3];
        logic signed [31:0] po [3];
        logic signed [15:0] no [3];
        wide_t              pacc;
        wide_t              nacc;
        out_item_t          r;
        e[0][0] = ONE_Q30 - twice_q30(pose_q.y, pose_q.y) - twice_q30(pose_q.z, pose_q.z);
        e[0][1] = twice_q30(pose_q.x, pose_q.y) - twice_q30(pose_q.w, pose_q.z);
        e[0][2] = twice_q30(pose_q.x, pose_q.z) + twice_q30(pose_q.w, pose_q.y);
        e[1][0] = twice_q30(pose_q.x, pose_q.y) + twice_q30(pose_q.w, pose_q.z);
        e[1][1] = ONE_Q30 - twice_q30(pose_q.x, pose_q.x) - twice_q30(pose_q.z, pose_q.z);
        e[1][2] = twice_q30(pose_q.y, pose_q.z) - twice_q30(pose_q.w, pose_q.x);
        e[2][0] = twice_q30(pose_q.x, pose_q.z) - twice_q30(pose_q.w, pose_q.y);
        e[2][1] = twice_q30(pose_q.y, pose_q.z) + twice_q30(pose_q.w, pose_q.x);
        e[2][2] = ONE_Q30 - twice_q30(pose_q.x, pose_q.x) - twice_q30(pose_q.y, pose_q.y);
        p[0] = pt.pos_x;  p[1] = pt.pos_y;  p[2] = pt.pos_z;
        n[0] = pt.norm_x; n[1] = pt.norm_y; n[2] = pt.norm_z;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                rot[i][j] = clamp32(e[i][j]);
        for (int i = 0; i < 3; i++)
        begin
            pacc = '0;
            nacc = '0;
            for (int j = 0; j < 3; j++)
            begin
                pacc = pacc + rot[i][j] * p[j];
                nacc = nacc + rot[i][j] * n[j];
            end
            // Q18.46 -> Q16.16 then translate; Q4.44 -> Q2.14
            pacc  = ((pacc + HALF_Q30) >>> 30) + pose_off[i];
            po[i] = clamp32(pacc);
            no[i] = clamp16((nacc + HALF_Q30) >>> 30);
        end
        r.out_pos_x      = po[0];
        r.out_pos_y      = po[1];
        r.out_pos_z      = po[2];
        r.out_norm_x     = no[0];
        r.out_norm_y     = no[1];
        r.out_norm_z     = no[2];
        r.out_curv_bits  = pt.curv_bits;
        r.out_inten_bits = pt.inten_bits;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        err_count++;
        if (err_count <= PRINT_CAP)
            $display("MISMATCH beat %0d %s: got %h expected %h",
                     points_seen, what, got, want);
    endtask

    // output beats sampled at the edge, so values are the pre-edge ones
    always @(posedge clk)
    begin
        out_item_t got;
        out_item_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            if (expected_points.size() == 0)
            begin
                report_mismatch("unexpected beat, pos_x", got.out_pos_x, '0);
            end
            else
            begin
                want = expected_points.pop_front();
                if (got.out_pos_x !== want.out_pos_x)
                    report_mismatch("out_pos_x", got.out_pos_x, want.out_pos_x);
                if (got.out_pos_y !== want.out_pos_y)
                    report_mismatch("out_pos_y", got.out_pos_y, want.out_pos_y);
                if (got.out_pos_z !== want.out_pos_z)
                    report_mismatch("out_pos_z", got.out_pos_z, want.out_pos_z);
                if (got.out_norm_x !== want.out_norm_x)
                    report_mismatch("out_norm_x", 32'(got.out_norm_x), 32'(want.out_norm_x));
                if (got.out_norm_y !== want.out_norm_y)
                    report_mismatch("out_norm_y", 32'(got.out_norm_y), 32'(want.out_norm_y));
                if (got.out_norm_z !== want.out_norm_z)
                    report_mismatch("out_norm_z", 32'(got.out_norm_z), 32'(want.out_norm_z));
                if (got.out_curv_bits !== want.out_curv_bits)
                    report_mismatch("out_curv_bits", got.out_curv_bits, want.out_curv_bits);
                if (got.out_inten_bits !== want.out_inten_bits)
                    report_mismatch("out_inten_bits", got.out_inten_bits,
                                    want.out_inten_bits);
            end
            points_seen++;
        end
    end

    // receiver: random m_tready, or a counted hold-off when one is requested
    always @(posedge clk)
    begin
        if (hold_req != 0)
        begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left != 0)
        begin
            m_tready <= 1'b0;
            hold_left--;
        end
        else
            m_tready <= ($urandom_range(99) >= dst_gap_pct);
    end

    // watchdog: too long without a beat on either side ends the run
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIM)
            begin
                $display("Watchdog: no beat for %0d cycles, %0d results outstanding",
                         STALL_LIM, expected_points.size());
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    // one input beat; prediction is queued at the accepting edge
    task automatic send_point(input in_item_t pt);
        while ($urandom_range(99) < src_gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pt;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        expected_points.insert(expected_points.size(), transform_point(pt));
        points_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_points.size() != 0)
            @(posedge clk);
        repeat (DRAIN_PAD) @(posedge clk);
    endtask

    // cfg_we left high; the caller drops it after the last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        unique case (idx)
            REG_OFFSET_X: pose_off[0] = val;
            REG_OFFSET_Y: pose_off[1] = val;
            REG_OFFSET_Z: pose_off[2] = val;
            REG_QUAT_X:   pose_q.x    = val;
            REG_QUAT_Y:   pose_q.y    = val;
            REG_QUAT_Z:   pose_q.z    = val;
            REG_QUAT_W:   pose_q.w    = val;
            default:      ;         // out of range, ignored
        endcase
    endtask

    task automatic apply_pose(input logic signed [31:0] ox, input logic signed [31:0] oy,
                              input logic signed [31:0] oz, input quat_t q);
        wait_drained();
        write_reg(REG_OFFSET_X, ox);
        write_reg(REG_OFFSET_Y, oy);
        write_reg(REG_OFFSET_Z, oz);
        write_reg(REG_QUAT_X, q.x);
        write_reg(REG_QUAT_Y, q.y);
        write_reg(REG_QUAT_Z, q.z);
        write_reg(REG_QUAT_W, q.w);
        cfg_we <= 1'b0;
        poses_applied++;
    endtask

    function automatic quat_t make_quat(input logic signed [31:0] x, input logic signed [31:0] y,
                                        input logic signed [31:0] z, input logic signed [31:0] w);
        quat_t q;
        q.x = x; q.y = y; q.z = z; q.w = w;
        return q;
    endfunction

    function automatic in_item_t make_point(
        input logic signed [31:0] px, input logic signed [31:0] py, input logic signed [31:0] pz,
        input logic signed [15:0] nx, input logic signed [15:0] ny, input logic signed [15:0] nz,
        input logic [31:0] curv, input logic [31:0] inten);
        in_item_t pt;
        pt.pos_x = px;  pt.pos_y = py;  pt.pos_z = pz;
        pt.norm_x = nx; pt.norm_y = ny; pt.norm_z = nz;
        pt.curv_bits = curv;
        pt.inten_bits = inten;
        return pt;
    endfunction

    // random direction normalised in reals, then scaled to Q2.30
    function automatic quat_t rand_unit_quat();
        real a, b, c, d, mag;
        a = real'(int'($urandom_range(2000000)) - 1000000);
        b = real'(int'($urandom_range(2000000)) - 1000000);
        c = real'(int'($urandom_range(2000000)) - 1000000);
        d = real'(int'($urandom_range(2000000)) - 1000000);
        mag = $sqrt(a * a + b * b + c * c + d * d);
        if (mag < 1.0)
            return make_quat(32'sd0, 32'sd0, 32'sd0, QUAT_W_RESET);
        return make_quat($rtoi(a / mag * 1073741824.0), $rtoi(b / mag * 1073741824.0),
                         $rtoi(c / mag * 1073741824.0), $rtoi(d / mag * 1073741824.0));
    endfunction

    // mostly within +-256.0 so results stay in range; some full-range words
    function automatic logic signed [31:0] rand_pos();
        if ($urandom_range(9) < 3)
            return $urandom;
        return int'($urandom_range(33554432)) - 16777216;
    endfunction

    function automatic logic signed [15:0] rand_norm();
        if ($urandom_range(9) < 3)
            return 16'($urandom);
        return 16'(int'($urandom_range(32768)) - 16384);
    endfunction

    function automatic in_item_t rand_point();
        return make_point(rand_pos(), rand_pos(), rand_pos(),
                          rand_norm(), rand_norm(), rand_norm(), $urandom, $urandom);
    endfunction

    function automatic logic signed [31:0] rand_offset();
        return int'($urandom_range(16777216)) - 8388608;
    endfunction

    task automatic random_pose(input int kind);
        unique case (kind % 4)
            0: apply_pose(rand_offset(), rand_offset(), rand_offset(), rand_unit_quat());
            1: apply_pose($urandom, $urandom, $urandom, rand_unit_quat());
            // raw words: mostly non-unit, matrix entries saturate
            2: apply_pose($urandom, $urandom, $urandom,
                          make_quat($urandom, $urandom, $urandom, $urandom));
            default:
            begin
                apply_pose(32'sd0, 32'sd0, 32'sd0, rand_unit_quat());
                @(posedge clk);
                write_reg(REG_UNUSED, $urandom);
                cfg_we <= 1'b0;
            end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // pose straight out of reset is identity: points pass unchanged
    task automatic test_reset_pose();
        send_point(make_point(32'sd0, 32'sd0, 32'sd0, 16'sd0, 16'sd0, 16'sd0, '0, '0));
        send_point(make_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                              16'sh7FFF, 16'sh7FFF, 16'sh7FFF, '1, '1));
        send_point(make_point(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                              16'sh8000, 16'sh8000, 16'sh8000, '0, '1));
        send_point(make_point(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0001_8000,
                              16'sh8000, 16'sh4000, -16'sh4000, '1, 32'hA5A5_5A5A));
    endtask

    task automatic test_rotation_offset();
        // quarter turn about z, offsets +1.5, -2.25, 0
        apply_pose(32'sh0001_8000, -32'sh0002_4000, 32'sd0,
                   make_quat(32'sd0, 32'sd0, SIN45, SIN45));
        send_point(make_point(32'sh0001_0000, 32'sd0, 32'sd0, 16'sh4000, 16'sd0, 16'sd0,
                              32'h1234_5678, 32'h8765_4321));
        send_point(make_point(32'sd0, 32'sh0003_0000, -32'sh0000_8000, 16'sd0, 16'sh4000,
                              16'sh4000, 32'h0, 32'hFFFF_FFFF));
        send_point(make_point(-32'sh0010_0000, 32'sh0000_0001, 32'sh7FFF_FFFF,
                              16'sh2D41, 16'sh2D41, 16'sd0, 32'hDEAD_BEEF, 32'h0));
        // translation pushes past both ends of the range
        apply_pose(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                   make_quat(32'sd0, 32'sd0, 32'sd0, QUAT_W_RESET));
        send_point(make_point(32'sh7FFF_FFFF, 32'sh0000_0001, 32'sh8000_0000,
                              16'sd0, 16'sd0, 16'sd0, '0, '0));
        apply_pose(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                   make_quat(32'sd0, 32'sd0, 32'sd0, QUAT_W_RESET));
        send_point(make_point(32'sh8000_0000, -32'sh0000_0001, 32'sh7FFF_FFFF,
                              16'sd0, 16'sd0, 16'sd0, '1, '1));
        // out-of-range register index must leave the pose alone
        wait_drained();
        write_reg(REG_UNUSED, 32'hFFFF_FFFF);
        cfg_we <= 1'b0;
        send_point(make_point(32'sh0000_1000, 32'sh0000_2000, 32'sh0000_3000,
                              16'sh1000, 16'sh2000, 16'sh3000, '1, '0));
    endtask

    task automatic test_non_unit_quat();
        apply_pose(32'sd0, 32'sd0, 32'sd0,
                   make_quat(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
        send_point(make_point(32'sh0001_0000, 32'sh0002_0000, -32'sh0003_0000,
                              16'sh4000, -16'sh4000, 16'sh2000, '0, '0));
        send_point(make_point(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
                              16'sh7FFF, 16'sh8000, 16'sh7FFF, '1, '1));
        apply_pose(32'sd0, 32'sd0, 32'sd0,
                   make_quat(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000));
        send_point(make_point(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000,
                              16'sh4000, 16'sh4000, 16'sh4000, '0, '1));
        send_point(make_point(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                              16'sh8000, 16'sh8000, 16'sh8000, '1, '0));
        // all-zero quaternion still gives the identity diagonal
        apply_pose(32'sd0, 32'sd0, 32'sd0, make_quat(32'sd0, 32'sd0, 32'sd0, 32'sd0));
        send_point(make_point(32'sh0012_3456, -32'sh0065_4321, 32'sh7FFF_FFFF,
                              16'sh1234, -16'sh1234, 16'sh8000, '1, '1));
        // half turn about x: negated most-negative normal saturates high
        apply_pose(32'sd0, 32'sd0, 32'sd0, make_quat(QUAT_W_RESET, 32'sd0, 32'sd0, 32'sd0));
        send_point(make_point(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                              16'sh8000, 16'sh8000, 16'sh8000, '0, '0));
    endtask

    // receiver holds off while the sender keeps offering: pipeline fills
    task automatic test_output_stall();
        apply_pose(rand_offset(), rand_offset(), rand_offset(), rand_unit_quat());
        src_gap_pct = 0;
        dst_gap_pct = 0;
        hold_req    = 400;
        for (int k = 0; k < 60; k++)
            send_point(rand_point());
        wait_drained();
    endtask

    task automatic test_random_stream(input int gap_src, input int gap_dst, input int count);
        src_gap_pct = gap_src;
        dst_gap_pct = gap_dst;
        for (int k = 0; k < count; k++)
        begin
            if (k % POSE_SPAN == 0)
                random_pose(poses_applied + k / POSE_SPAN);
            send_point(rand_point());
        end
        wait_drained();
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        pose_off[0] = '0;
        pose_off[1] = '0;
        pose_off[2] = '0;
        pose_q      = make_quat(32'sd0, 32'sd0, 32'sd0, QUAT_W_RESET);
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_pose();
        test_rotation_offset();
        test_non_unit_quat();
        test_output_stall();
        test_random_stream(12, 68, 560);
        test_random_stream(68, 12, 560);
        test_random_stream(0, 0, 560);

        wait_drained();
        $display("Run covered %0d points over %0d poses: corners, saturation, non-unit",
                 points_sent, poses_applied);
        $display("quaternions, ignored index, long output stall; %0d beats checked.",
                 points_seen);
        if (err_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
